/* hw/rtl/rgb_to_hsv_8bit_top_macros.svh */
// assertion macros for the rgb to hsv converter
// used by rgb_to_hsv_8bit_top; expects clk and rst in scope
`ifndef RGB_TO_HSV_8BIT_TOP_MACROS_SVH
`define RGB_TO_HSV_8BIT_TOP_MACROS_SVH

// checked only outside reset
`define RGBHSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define RGBHSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/rgbhsv_pkg.sv */
// shared widths, divider types and the divider step function
// no dependencies
`default_nettype none

package rgbhsv_pkg;

  localparam int CHAN_W     = 8;
  localparam int QUO_W      = 8;
  localparam int DEN_W      = 11;                 // 6 * chroma < 2048
  localparam int NUM_W      = DEN_W + QUO_W;      // numerator < den * 256
  localparam int DIV_BITS   = 2;                  // quotient bits per stage
  localparam int DIV_STAGES = QUO_W / DIV_BITS;
  localparam int PIPE_DEPTH = 3 + DIV_STAGES;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

  // one restoring division step: bring down a numerator bit, subtract if it fits
  function automatic div_t div_step(input div_t s);
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;
    div_t           o;
    trial = {s.rem, s.low[QUO_W-1]};
    diff  = trial - {1'b0, s.den};
    fits  = (trial >= {1'b0, s.den});
    o     = s;
    o.rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    o.low = {s.low[QUO_W-2:0], 1'b0};
    o.quo = {s.quo[QUO_W-2:0], fits};
    return o;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgbhsv_pix_if.sv */
// input channel: one rgba pixel per transaction
// depends on rgbhsv_pkg
`default_nettype none

interface rgbhsv_pix_if;
  import rgbhsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/rgbhsv_hsv_if.sv */
// output channel: one hsv pixel plus alpha per transaction
// depends on rgbhsv_pkg
`default_nettype none

interface rgbhsv_hsv_if;
  import rgbhsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] hue;
  logic [CHAN_W-1:0] saturation;
  logic [CHAN_W-1:0] brightness;
  logic [CHAN_W-1:0] alpha_out;

  modport source (output valid, output hue, output saturation, output brightness,
                  output alpha_out, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input alpha_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rgb_to_hsv_8bit_top.sv */
// rgb to hsv converter, top level
// depends on rgbhsv_pkg, rgbhsv_pix_if, rgbhsv_hsv_if, rgbhsv_div and the macros header
`default_nettype none

// Converts a stream of 8-bit rgba pixels to 8-bit hue, saturation and
// brightness, with alpha copied through. One pixel is taken every clock
// unless the output stalls. In order, one stage picks the largest and
// smallest channel and the sector, one forms chroma and the hue sum,
// one forms numerators and denominators, and the two divisions
// (hue = 255*sum/(6*chroma), saturation = 255*chroma/max) run side by side
// in a 4-stage restoring divider that settles 2 quotient bits per stage.
// The whole pipe advances together whenever the output register is empty or
// being taken, so a stall on the output holds every stage in place; a gray
// pixel gives hue 0 and a black pixel saturation 0, with exact floor
// rounding throughout.

`include "rgb_to_hsv_8bit_top_macros.svh"

module rgb_to_hsv_8bit_top (
  input  logic         clk,
  input  logic         rst,
  rgbhsv_pix_if.sink   pix,
  rgbhsv_hsv_if.source hsv
);
  import rgbhsv_pkg::*;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // global advance: the pipe moves when the output slot frees up
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;

  assign adv       = !vld[PIPE_DEPTH-1] || hsv.ready;
  assign pix.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], pix.valid};
    end
  end

  // stage 1: max, min, sector and signed channel difference
  sector_t           sect_next;
  logic [CHAN_W-1:0] hi_next;
  logic [CHAN_W-1:0] lo_next;
  logic [CHAN_W:0]   diff_next;     // two's complement, one bit wider

  sector_t           s1_sect;
  logic [CHAN_W-1:0] s1_hi;
  logic [CHAN_W-1:0] s1_lo;
  logic [CHAN_W:0]   s1_diff;
  logic [CHAN_W-1:0] s1_alpha;

  always_comb begin
    logic [CHAN_W-1:0] lo_rg;
    lo_rg   = (pix.green < pix.red) ? pix.green : pix.red;
    lo_next = (pix.blue < lo_rg) ? pix.blue : lo_rg;
    // ties favor red, then green
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      sect_next = SECT_RED;
      hi_next   = pix.red;
      diff_next = {1'b0, pix.green} - {1'b0, pix.blue};
    end else if (pix.green >= pix.blue) begin
      sect_next = SECT_GREEN;
      hi_next   = pix.green;
      diff_next = {1'b0, pix.blue} - {1'b0, pix.red};
    end else begin
      sect_next = SECT_BLUE;
      hi_next   = pix.blue;
      diff_next = {1'b0, pix.red} - {1'b0, pix.green};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sect  <= sect_next;
      s1_hi    <= hi_next;
      s1_lo    <= lo_next;
      s1_diff  <= diff_next;
      s1_alpha <= pix.alpha;
    end
  end

  // stage 2: chroma and the sector-offset hue sum, always in [0, 6*chroma) for nonzero chroma
  logic [CHAN_W-1:0] chroma_next;
  logic [DEN_W-1:0]  sum_next;

  logic [CHAN_W-1:0] s2_chroma;
  logic [DEN_W-1:0]  s2_sum;
  logic [CHAN_W-1:0] s2_hi;
  logic [CHAN_W-1:0] s2_alpha;

  always_comb begin
    logic [DEN_W:0] c12;
    logic [DEN_W:0] d12;
    logic [DEN_W:0] s12;
    chroma_next = s1_hi - s1_lo;
    c12 = {{(DEN_W+1-CHAN_W){1'b0}}, chroma_next};
    d12 = {{(DEN_W-CHAN_W){s1_diff[CHAN_W]}}, s1_diff};
    case (s1_sect)
      SECT_RED: begin
        // negative sum wraps into the top of the turn
        s12 = d12 + (s1_diff[CHAN_W] ? ((c12 << 2) + (c12 << 1)) : '0);
      end
      SECT_GREEN: begin
        s12 = (c12 << 1) + d12;
      end
      SECT_BLUE: begin
        s12 = (c12 << 2) + d12;
      end
      default: begin
        s12 = '0;
      end
    endcase
    sum_next = s12[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_chroma <= chroma_next;
      s2_sum    <= sum_next;
      s2_hi     <= s1_hi;
      s2_alpha  <= s1_alpha;
    end
  end

  // stage 3: numerators times 255, denominators; a zero divisor becomes 1
  // with a zero numerator so the quotient comes out 0
  div_req_t hue_req_next;
  div_req_t sat_req_next;
  div_req_t hue_req;
  div_req_t sat_req;
  logic [CHAN_W-1:0] s3_hi;
  logic [CHAN_W-1:0] s3_alpha;

  always_comb begin
    logic [DEN_W-1:0]  c11;
    logic [NUM_W-1:0]  sum19;
    logic [NUM_W-1:0]  chr19;
    c11   = {{(DEN_W-CHAN_W){1'b0}}, s2_chroma};
    sum19 = {{(NUM_W-DEN_W){1'b0}}, s2_sum};
    chr19 = {{(NUM_W-CHAN_W){1'b0}}, s2_chroma};

    hue_req_next.num = (sum19 << CHAN_W) - sum19;
    hue_req_next.den = (s2_chroma == '0) ? DEN_W'(1) : ((c11 << 2) + (c11 << 1));

    sat_req_next.num = (chr19 << CHAN_W) - chr19;
    sat_req_next.den = (s2_hi == '0) ? DEN_W'(1)
                                     : {{(DEN_W-CHAN_W){1'b0}}, s2_hi};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_req  <= hue_req_next;
      sat_req  <= sat_req_next;
      s3_hi    <= s2_hi;
      s3_alpha <= s2_alpha;
    end
  end

  // stages 4 to 7: the two dividers, side data rides alongside
  logic [QUO_W-1:0]  hue_quo;
  logic [QUO_W-1:0]  sat_quo;
  logic [CHAN_W-1:0] bright_pipe [DIV_STAGES];
  logic [CHAN_W-1:0] alpha_pipe  [DIV_STAGES];

  rgbhsv_div u_hue_div (
    .clk (clk),
    .en  (adv),
    .req (hue_req),
    .quo (hue_quo)
  );

  rgbhsv_div u_sat_div (
    .clk (clk),
    .en  (adv),
    .req (sat_req),
    .quo (sat_quo)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      bright_pipe[0] <= s3_hi;
      alpha_pipe[0]  <= s3_alpha;
      for (int k = 1; k < DIV_STAGES; k++) begin
        bright_pipe[k] <= bright_pipe[k-1];
        alpha_pipe[k]  <= alpha_pipe[k-1];
      end
    end
  end

  assign hsv.valid      = vld[PIPE_DEPTH-1];
  assign hsv.hue        = hue_quo;
  assign hsv.saturation = sat_quo;
  assign hsv.brightness = bright_pipe[DIV_STAGES-1];
  assign hsv.alpha_out  = alpha_pipe[DIV_STAGES-1];

  // hue covers less than a full turn, so 255 means a divider slip
  `RGBHSV_ASSERT(a_hue_below_turn, hsv.valid |-> hsv.hue != 8'hff, "hue reached 255")
  // a black pixel must report zero saturation
  `RGBHSV_ASSERT(a_black_no_sat, (hsv.valid && hsv.brightness == '0) |-> hsv.saturation == '0,
    "nonzero saturation on black pixel")
  // an empty output slot never blocks the input
  `RGBHSV_ASSERT(a_empty_accepts, !hsv.valid |-> pix.ready, "input stalled with empty output")
  // nothing comes out right after reset
  `RGBHSV_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !hsv.valid, "output valid after reset")

endmodule

`default_nettype wire

/* hw/rtl/rgbhsv_div.sv */
// pipelined restoring divider, DIV_BITS quotient bits per register stage
// depends on rgbhsv_pkg; caller guarantees num < den * 2**QUO_W and den != 0
`default_nettype none

module rgbhsv_div (
  input  logic                         clk,
  input  logic                         en,
  input  rgbhsv_pkg::div_req_t         req,
  output logic [rgbhsv_pkg::QUO_W-1:0] quo
);
  import rgbhsv_pkg::*;

  div_t stage_in  [DIV_STAGES];
  div_t stage_out [DIV_STAGES];
  div_t stage     [DIV_STAGES];

  // top numerator bits already sit below den, so they seed the remainder
  always_comb begin
    stage_in[0].rem = req.num[NUM_W-1:QUO_W];
    stage_in[0].low = req.num[QUO_W-1:0];
    stage_in[0].den = req.den;
    stage_in[0].quo = '0;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign stage_in[k] = stage[k-1];
    end

    always_comb begin
      div_t s;
      s = stage_in[k];
      for (int b = 0; b < DIV_BITS; b++) begin
        s = div_step(s);
      end
      stage_out[k] = s;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage[k] <= stage_out[k];
      end
    end
  end

  assign quo = stage[DIV_STAGES-1].quo;

endmodule

`default_nettype wire
